// ===== hdl/duty_sorted_channel_list_macros.svh =====
// ----------------------------------------------------------------------------
// duty sorted channel list: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DUTY_SORTED_CHANNEL_LIST_MACROS_SVH
`define DUTY_SORTED_CHANNEL_LIST_MACROS_SVH

// same-cycle implication
`define DSL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dsl_pkg.sv =====
// ----------------------------------------------------------------------------
// dsl_pkg
// types, constants and reset table shared by the duty sorted channel list
// ----------------------------------------------------------------------------
`default_nettype none

package dsl_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CH_W         = 3;
  localparam int DUTY_W       = 16;
  localparam int OPC_W        = 2;
  localparam int COUNT_OUT_W  = 4;
  localparam int PACKED_SLOTS = 8;
  localparam int PACKED_W     = PACKED_SLOTS * CH_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from the word address bit
  localparam logic [0:0] REG_PERIOD = 1'b0;

  localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'd20000;
  localparam logic [DUTY_W-1:0] DUTY_MARGIN  = 16'd10;

  typedef enum logic [OPC_W-1:0] {
    OP_ENABLE  = 2'd0,
    OP_DISABLE = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REMOVE,
    ST_STORE,
    ST_SCAN,
    ST_INSERT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;     // capture the command beat
    logic reject;   // flag duty out of range
    logic cap_d;    // capture the key duty
    logic remove;   // take the channel out of the list
    logic store;    // write the new duty
    logic scan;     // read duty through the list entry at pos
    logic inc_pos;  // step the insertion pointer
    logic insert;   // open the gap and place the channel
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    ch_ok;
    logic    listed;
    logic    full;
    logic    range_ok;
    logic    scan_more;
  } dp_stat_t;

  function automatic logic [DUTY_W-1:0] duty_reset_val(input int idx);
    logic [DUTY_W-1:0] v;
    case (idx)
      0:       v = 16'd19010;
      1:       v = 16'd18990;
      2:       v = 16'd18000;
      3:       v = 16'd19020;
      4:       v = 16'd18500;
      5:       v = 16'd18690;
      6:       v = 16'd2100;
      7:       v = 16'd2000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsl_ctrl
// sequencer for check, remove, store, scan and insert of one command
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire dsl_pkg::dp_stat_t stat,
  output dsl_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   done
);
  import dsl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.ch_ok) begin
          state_next = ST_RESULT;
        end else begin
          unique case (stat.opcode)
            OP_ENABLE: begin
              if (stat.listed || stat.full) begin
                state_next = ST_RESULT;
              end else begin
                cmd.cap_d  = 1'b1;
                state_next = ST_SCAN;
              end
            end
            OP_DISABLE: begin
              state_next = stat.listed ? ST_REMOVE : ST_RESULT;
            end
            OP_CHANGE: begin
              if (stat.range_ok) begin
                state_next = ST_REMOVE;
              end else begin
                cmd.reject = 1'b1;
                state_next = ST_RESULT;
              end
            end
            OP_NOP: begin
              state_next = ST_RESULT;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = (stat.opcode == OP_CHANGE) ? ST_STORE : ST_RESULT;
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        cmd.cap_d  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_more) begin
          cmd.inc_pos = 1'b1;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/dsl_dp.sv =====
// ----------------------------------------------------------------------------
// dsl_dp
// ordered channel list, duty table, insertion pointer and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module dsl_dp #(
  parameter int CHANNELS = dsl_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dsl_pkg::dp_cmd_t              cmd,
  output dsl_pkg::dp_stat_t                  stat,
  input  wire logic [dsl_pkg::OPC_W-1:0]     opcode,
  input  wire logic [dsl_pkg::CH_W-1:0]      channel,
  input  wire logic [dsl_pkg::DUTY_W-1:0]    duty,
  input  wire logic [dsl_pkg::DUTY_W-1:0]    period_us,
  output logic                               status,
  output logic [dsl_pkg::COUNT_OUT_W-1:0]    active_count,
  output logic [dsl_pkg::PACKED_W-1:0]       order_packed
);
  import dsl_pkg::*;

  localparam int IW = $clog2(CHANNELS);
  localparam int CW = $clog2(CHANNELS + 1);
  localparam int XW = (IW > CH_W) ? IW : CH_W;

  opcode_t           op_q;
  logic [CH_W-1:0]   ch_q;
  logic [DUTY_W-1:0] duty_q;
  logic              status_q;

  logic [CH_W-1:0]   order [CHANNELS];
  logic [CH_W-1:0]   order_next [CHANNELS];
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [DUTY_W-1:0] duty_tab [CHANNELS];
  logic [CW-1:0]     pos;
  logic [DUTY_W-1:0] key_d;

  logic [XW-1:0]     ch_x;
  logic [XW-1:0]     ent_x;
  logic [CH_W-1:0]   ent;
  logic [IW-1:0]     ch_idx;
  logic [IW-1:0]     ent_idx;
  logic [IW-1:0]     rd_idx;
  logic [DUTY_W-1:0] rd_data;
  logic              hit;
  logic [IW-1:0]     hit_idx;

  // channel number to table index
  assign ch_x    = XW'(ch_q);
  assign ch_idx  = ch_x[IW-1:0];
  assign ent     = order[pos[IW-1:0]];
  assign ent_x   = XW'(ent);
  assign ent_idx = ent_x[IW-1:0];

  // single read port on the duty table
  assign rd_idx  = cmd.scan ? ent_idx : ch_idx;
  assign rd_data = duty_tab[rd_idx];

  // lowest list slot holding the channel
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      if ((CW'(k) < count) && (order[k] == ch_q)) begin
        hit     = 1'b1;
        hit_idx = IW'(k);
      end
    end
  end

  always_comb begin
    stat.opcode    = op_q;
    stat.ch_ok     = (int'(ch_q) < CHANNELS);
    stat.listed    = hit;
    stat.full      = (count >= CW'(CHANNELS));
    stat.range_ok  = (duty_q >= DUTY_MARGIN) &&
                     (({1'b0, duty_q} + {1'b0, DUTY_MARGIN}) <= {1'b0, period_us});
    stat.scan_more = (pos < count) && (rd_data < key_d);
  end

  always_comb begin
    order_next = order;
    count_next = count;
    if (cmd.remove && hit) begin
      for (int k = 0; k < CHANNELS - 1; k++) begin
        if (IW'(k) >= hit_idx) begin
          order_next[k] = order[k + 1];
        end
      end
      order_next[CHANNELS - 1] = '0;
      count_next = count - 1'b1;
    end else if (cmd.insert) begin
      for (int k = 1; k < CHANNELS; k++) begin
        if (CW'(k) > pos) begin
          order_next[k] = order[k - 1];
        end
      end
      for (int k = 0; k < CHANNELS; k++) begin
        if (CW'(k) == pos) begin
          order_next[k] = ch_q;
        end
      end
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pos      <= '0;
      status_q <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        order[k]    <= '0;
        duty_tab[k] <= duty_reset_val(k);
      end
    end else begin
      order <= order_next;
      count <= count_next;
      if (cmd.load) begin
        pos      <= '0;
        status_q <= 1'b0;
      end else if (cmd.inc_pos) begin
        pos <= pos + 1'b1;
      end
      if (cmd.reject) begin
        status_q <= 1'b1;
      end
      if (cmd.store) begin
        duty_tab[ch_idx] <= duty_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode_t'(opcode);
      ch_q   <= channel;
      duty_q <= duty;
    end
    if (cmd.cap_d) begin
      key_d <= cmd.store ? duty_q : rd_data;
    end
  end

  assign status       = status_q;
  assign active_count = COUNT_OUT_W'(count);

  for (genvar g = 0; g < PACKED_SLOTS; g++) begin : g_slot
    if (g < CHANNELS) begin : g_used
      assign order_packed[CH_W*g +: CH_W] = (CW'(g) < count) ? order[g] : '0;
    end else begin : g_empty
      assign order_packed[CH_W*g +: CH_W] = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/duty_sorted_channel_list.sv =====
// ----------------------------------------------------------------------------
// duty_sorted_channel_list
// list of active pwm channels kept in rising duty order, with duty table
// ----------------------------------------------------------------------------
// commands come in on start/opcode/channel/duty and are taken at an edge
// where start is high and busy is low. busy stays high until the result
// beat, which sits on status/active_count/order_packed for one cycle with
// done high; the receiver cannot stall it, so it must take it then.
// a command runs through check, then remove for disable, scan and insert
// for enable, or remove, store, scan and insert for change duty, before
// the result; rejected or empty commands go from check to the result.
// the scan reads one duty table entry per cycle through the list. busy
// drops the cycle after the result beat, so the next command is taken
// in the cycle after done at the earliest.
// the apb port holds period_us (address 0); write it only while idle.
// synchronous reset empties the list, loads the default duties and sets
// period_us to 20000.
// ----------------------------------------------------------------------------
`default_nettype none

`include "duty_sorted_channel_list_macros.svh"

module duty_sorted_channel_list #(
  parameter int CHANNELS = dsl_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [dsl_pkg::OPC_W-1:0]         opcode,
  input  wire logic [dsl_pkg::CH_W-1:0]          channel,
  input  wire logic [dsl_pkg::DUTY_W-1:0]        duty,
  output logic                                   done,
  output logic                                   status,
  output logic [dsl_pkg::COUNT_OUT_W-1:0]        active_count,
  output logic [dsl_pkg::PACKED_W-1:0]           order_packed,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dsl_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [dsl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dsl_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import dsl_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [DUTY_W-1:0] period_us;
  logic              wr_en;
  logic [0:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      period_us <= PERIOD_RESET;
    end else if (wr_en && (reg_idx == REG_PERIOD)) begin
      period_us <= pwdata[DUTY_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = APB_DATA_W'(period_us);
      default:    prdata = '0;
    endcase
  end

  dsl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dsl_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .channel      (channel),
    .duty         (duty),
    .period_us    (period_us),
    .status       (status),
    .active_count (active_count),
    .order_packed (order_packed)
  );

  `DSL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "command taken but not busy")
  `DSL_ASSERT_IMPLY(a_end_on_result, clk, rst, $fell(busy) && !$past(rst), $past(done), "busy dropped without a result beat")
  `DSL_ASSERT_NEXT(a_idle_list_stable, clk, rst, !busy && !start, $stable(active_count) && $stable(order_packed), "list changed while idle")

endmodule

`default_nettype wire

// ===== verif/duty_sorted_channel_list_test.sv =====
// ----------------------------------------------------------------------------
// duty_sorted_channel_list_test
// self-checking bench for the duty sorted pwm channel list
// ----------------------------------------------------------------------------
// commands go in through start/busy from a queue of pending commands. Each
// accepted beat is run through a local model of the ordered list and the
// duty table, and the result beat on done is compared field by field. The
// period register is rewritten over apb between phases, across values from
// the full 16-bit range to ones where every duty change is refused, with
// the command side idling at several rates.
// ----------------------------------------------------------------------------

module duty_sorted_channel_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dsl_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};

  typedef struct {
    opcode_t           op;
    logic [CH_W-1:0]   ch;
    logic [DUTY_W-1:0] duty;
  } command_t;

  typedef struct {
    logic                   status;
    logic [COUNT_OUT_W-1:0] count;
    logic [PACKED_W-1:0]    order;
  } list_view_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OPC_W-1:0]       opcode = '0;
  logic [CH_W-1:0]        channel = '0;
  logic [DUTY_W-1:0]      duty = '0;
  logic                   done;
  logic                   status;
  logic [COUNT_OUT_W-1:0] active_count;
  logic [PACKED_W-1:0]    order_packed;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  duty_sorted_channel_list #(
    .CHANNELS(CHANNELS_DEF)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .channel(channel),
    .duty(duty),
    .done(done),
    .status(status),
    .active_count(active_count),
    .order_packed(order_packed),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // model of the list, the duty table and the period register
  logic [DUTY_W-1:0] period_model = PERIOD_RESET;
  logic [CH_W-1:0]   order_model [CHANNELS_DEF];
  int                count_model = 0;
  logic [DUTY_W-1:0] duty_model [CHANNELS_DEF] =
    '{16'd19010, 16'd18990, 16'd18000, 16'd19020,
      16'd18500, 16'd18690, 16'd2100, 16'd2000};

  command_t   queued_cmds[$];
  list_view_t expected_views[$];
  command_t   next_cmd;
  list_view_t want;
  int         idle_pct = 0;
  int         errors = 0;
  int         checked = 0;
  int         refused = 0;
  int         longest = 0;
  int         cycle_count = 0;

  initial begin
    foreach (order_model[i]) order_model[i] = '0;
  end

  function automatic void drop_channel(input logic [CH_W-1:0] ch);
    for (int i = 0; i < count_model; i++) begin
      if (order_model[i] == ch) begin
        for (int k = i + 1; k < count_model; k++) order_model[k-1] = order_model[k];
        count_model--;
        order_model[count_model] = '0;
        return;
      end
    end
  endfunction

  // new channel goes in front of the first entry whose duty is not lower
  function automatic void place_channel(input logic [CH_W-1:0] ch);
    int pos;
    logic [DUTY_W-1:0] d;
    if (count_model >= CHANNELS_DEF) return;
    for (int i = 0; i < count_model; i++) if (order_model[i] == ch) return;
    d = duty_model[ch];
    pos = 0;
    while (pos < count_model && duty_model[order_model[pos]] < d) pos++;
    for (int k = count_model; k > pos; k--) order_model[k] = order_model[k-1];
    order_model[pos] = ch;
    count_model++;
  endfunction

  function automatic void apply_command(input opcode_t op, input logic [CH_W-1:0] ch,
                                        input logic [DUTY_W-1:0] d);
    list_view_t v;
    v.status = 1'b0;
    v.order = '0;
    case (op)
      OP_ENABLE: begin
        place_channel(ch);
      end
      OP_DISABLE: begin
        drop_channel(ch);
      end
      OP_CHANGE: begin
        // range check without wrap, so a period under 20 refuses every duty
        if (int'(d) < int'(DUTY_MARGIN) || int'(d) + int'(DUTY_MARGIN) > int'(period_model)) begin
          v.status = 1'b1;
        end else begin
          drop_channel(ch);
          duty_model[ch] = d;
          place_channel(ch);
        end
      end
      default: ;
    endcase
    v.count = COUNT_OUT_W'(count_model);
    for (int i = 0; i < count_model && i < PACKED_SLOTS; i++)
      v.order[CH_W*i +: CH_W] = order_model[i];
    expected_views.push_back(v);
  endfunction

  // command driver: a beat held on start stays until busy lets it in
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) apply_command(opcode_t'(opcode), channel, duty);
      if (!start || !busy) begin
        if (queued_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_cmd = queued_cmds.pop_front();
          start   <= 1'b1;
          opcode  <= next_cmd.op;
          channel <= next_cmd.ch;
          duty    <= next_cmd.duty;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_views.size() == 0) begin
        $display("%0t: result beat with none expected: status %0d count %0d order %h",
                 $time, status, active_count, order_packed);
        errors++;
      end else begin
        want = expected_views.pop_front();
        checked++;
        if (want.status) refused++;
        if (int'(want.count) > longest) longest = int'(want.count);
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (active_count !== want.count) begin
          $display("%0t: active_count expected %0d actual %0d", $time, want.count,
                   active_count);
          errors++;
        end
        if (order_packed !== want.order) begin
          $display("%0t: order_packed expected %h actual %h", $time, want.order,
                   order_packed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_views.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_cmd(input opcode_t op, input int ch, input int d);
    command_t c;
    c.op = op;
    c.ch = CH_W'(ch);
    c.duty = DUTY_W'(d);
    queued_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_cmds.size() > 0 || start || expected_views.size() > 0);
  endtask

  task automatic write_period(input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PERIOD_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    period_model = DUTY_W'(value);
    @(negedge clk);
  endtask

  int phase_period[6] = '{65535, 20, 15, 20000, 1000, 300};
  int phase_idle[6]   = '{0, 58, 28, 58, 28, 0};
  int phase_items[6]  = '{150, 60, 30, 150, 150, 60};

  initial begin
    int p;
    int d;
    int pick;
    int op_pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: fill the list, duplicates, range edges, ties, no-op
    idle_pct = 0;
    queue_cmd(OP_ENABLE, 7, 0);
    queue_cmd(OP_ENABLE, 6, 65535);
    queue_cmd(OP_ENABLE, 6, 0);
    for (int c = 0; c < 6; c++) queue_cmd(OP_ENABLE, c, 0);
    queue_cmd(OP_ENABLE, 0, 0);
    queue_cmd(OP_CHANGE, 3, 10);
    queue_cmd(OP_CHANGE, 0, 9);
    queue_cmd(OP_CHANGE, 1, 19990);
    queue_cmd(OP_CHANGE, 2, 19991);
    queue_cmd(OP_CHANGE, 0, 65535);
    queue_cmd(OP_CHANGE, 0, 0);
    queue_cmd(OP_CHANGE, 4, 10);
    queue_cmd(OP_NOP, 7, 65535);
    queue_cmd(OP_DISABLE, 5, 0);
    queue_cmd(OP_DISABLE, 5, 0);
    queue_cmd(OP_CHANGE, 5, 5000);
    queue_cmd(OP_DISABLE, 4, 0);
    queue_cmd(OP_DISABLE, 1, 0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_period(phase_period[ph]);
      idle_pct = phase_idle[ph];
      p = phase_period[ph];
      for (int n = 0; n < phase_items[ph]; n++) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          d = $urandom_range(65535);
        end else if (pick == 1) begin
          d = $urandom_range(15);
        end else if (pick == 2) begin
          // around the top of the accepted range
          d = p - 12 + $urandom_range(4);
          if (d < 0) d = 0;
        end else if (p < 20) begin
          d = 10;
        end else if (pick <= 5) begin
          // a few shared values so equal duties meet in the list
          d = 10 + (p - 20) * $urandom_range(3) / 3;
        end else begin
          d = $urandom_range(p - 10, 10);
        end
        op_pick = $urandom_range(99);
        if (op_pick < 35) queue_cmd(OP_ENABLE, $urandom_range(7), d);
        else if (op_pick < 60) queue_cmd(OP_DISABLE, $urandom_range(7), d);
        else if (op_pick < 95) queue_cmd(OP_CHANGE, $urandom_range(7), d);
        else queue_cmd(OP_NOP, $urandom_range(7), d);
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (expected_views.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_views.size());
      errors += expected_views.size();
    end
    $display("%0d commands checked over 7 period settings; %0d duty changes refused,",
             checked, refused);
    $display("list grew to %0d entries; %0d mismatches", longest, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dsl_pkg.sv
hdl/dsl_ctrl.sv
hdl/dsl_dp.sv
hdl/duty_sorted_channel_list.sv
verif/duty_sorted_channel_list_test.sv
